FILE: rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared widths, byte-class masks and the item structures that pass between
// the stages of the decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CpW      = 31;
    localparam int unsigned PendW    = 3;
    localparam int unsigned ContBits = 6;

    // Masks and match patterns for the lead byte classes.
    localparam logic [ByteW-1:0] MaskTop1   = 8'h80;
    localparam logic [ByteW-1:0] MaskTop3   = 8'he0;
    localparam logic [ByteW-1:0] MaskTop4   = 8'hf0;
    localparam logic [ByteW-1:0] MaskTop5   = 8'hf8;
    localparam logic [ByteW-1:0] MaskTop6   = 8'hfc;
    localparam logic [ByteW-1:0] MaskTop7   = 8'hfe;
    localparam logic [ByteW-1:0] Lead2      = 8'hc0;
    localparam logic [ByteW-1:0] Lead3      = 8'he0;
    localparam logic [ByteW-1:0] Lead4      = 8'hf0;
    localparam logic [ByteW-1:0] Lead5      = 8'hf8;
    localparam logic [ByteW-1:0] Lead6      = 8'hfc;
    localparam logic [ByteW-1:0] MaskCont   = 8'h3f;
    localparam logic [ByteW-1:0] MaskData2  = 8'h1f;
    localparam logic [ByteW-1:0] MaskData3  = 8'h0f;
    localparam logic [ByteW-1:0] MaskData4  = 8'h07;
    localparam logic [ByteW-1:0] MaskData5  = 8'h03;
    localparam logic [ByteW-1:0] MaskData6  = 8'h01;

    // Continuation bytes still expected after each kind of lead byte.
    localparam logic [PendW-1:0] Pend2 = 3'd1;
    localparam logic [PendW-1:0] Pend3 = 3'd2;
    localparam logic [PendW-1:0] Pend4 = 3'd3;
    localparam logic [PendW-1:0] Pend5 = 3'd4;
    localparam logic [PendW-1:0] Pend6 = 3'd5;
    localparam logic [PendW-1:0] PendNone = 3'd0;

    localparam logic WideModeReset = 1'b1;

    // One input byte held in the input register.
    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             end_of_string;
    } t_item;

    // One decoded result, with a flag saying whether the byte produced one.
    typedef struct packed {
        logic           emit;
        logic [CpW-1:0] code_point;
        logic           bad_sequence;
        logic           last_result;
    } t_result;

endpackage

FILE: rtl/u8d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Byte input channel, code point result channel and the mode write channel,
// each with valid/ready flow control.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic        bad_sequence;
    logic        last_result;

    modport source (output valid, output code_point, output bad_sequence,
                    output last_result, input ready);
    modport sink   (input valid, input code_point, input bad_sequence,
                    input last_result, output ready);
endinterface

interface u8d_cfg_if;
    logic valid;
    logic ready;
    logic wide_mode;

    modport source (output valid, output wide_mode, input ready);
    modport sink   (input valid, input wide_mode, output ready);
endinterface

FILE: rtl/u8d_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Holds one accepted byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module u8d_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  u8d_pkg::t_item i_item,
    input  logic           i_consume,
    output logic           o_valid,
    output u8d_pkg::t_item o_item
);
    import u8d_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    // A new item may enter when the register is empty or is being drained.
    assign o_ready = !r_valid || i_consume;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/u8d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder step logic
// Classifies each byte against the open sequence, gathers code point bits
// and flags bad lead bytes and truncated sequences.
// ----------------------------------------------------------------------------
module u8d_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_wide_mode,
    input  u8d_pkg::t_item   i_item,
    output u8d_pkg::t_result o_result
);
    import u8d_pkg::*;

    logic [CpW-1:0]   r_partial;
    logic [PendW-1:0] r_pending;
    logic [CpW-1:0]   n_partial;
    logic [PendW-1:0] n_pending;
    logic [ByteW-1:0] b;
    logic             eos;
    logic [CpW-1:0]   shifted;
    logic [PendW-1:0] dec;
    t_result          res;

    assign b   = i_item.in_byte;
    assign eos = i_item.end_of_string;
    assign shifted = {r_partial[CpW-ContBits-1:0], b[ContBits-1:0]};
    assign dec     = r_pending - 3'd1;

    // Next state and result for the byte in the input register.
    always_comb begin
        n_partial        = r_partial;
        n_pending        = r_pending;
        res.emit         = 1'b0;
        res.code_point   = '0;
        res.bad_sequence = 1'b0;
        res.last_result  = eos;
        if (r_pending != PendNone) begin
            // Continuation byte: shift in six bits without checking the tag.
            n_partial = shifted;
            n_pending = dec;
            if (dec == PendNone) begin
                res.emit       = 1'b1;
                res.code_point = shifted;
                n_partial      = '0;
            end else if (eos) begin
                res.emit         = 1'b1;
                res.bad_sequence = 1'b1;
                res.last_result  = 1'b1;
                n_partial        = '0;
                n_pending        = PendNone;
            end
        end else begin
            // Lead byte.
            if ((b & MaskTop1) == '0) begin
                res.emit       = 1'b1;
                res.code_point = {{(CpW-ByteW){1'b0}}, b};
            end else begin
                if ((b & MaskTop3) == Lead2) begin
                    n_partial = {{(CpW-ByteW){1'b0}}, b & MaskData2};
                    n_pending = Pend2;
                end else if ((b & MaskTop4) == Lead3) begin
                    n_partial = {{(CpW-ByteW){1'b0}}, b & MaskData3};
                    n_pending = Pend3;
                end else if (i_wide_mode && (b & MaskTop5) == Lead4) begin
                    n_partial = {{(CpW-ByteW){1'b0}}, b & MaskData4};
                    n_pending = Pend4;
                end else if (i_wide_mode && (b & MaskTop6) == Lead5) begin
                    n_partial = {{(CpW-ByteW){1'b0}}, b & MaskData5};
                    n_pending = Pend5;
                end else if (i_wide_mode && (b & MaskTop7) == Lead6) begin
                    n_partial = {{(CpW-ByteW){1'b0}}, b & MaskData6};
                    n_pending = Pend6;
                end else begin
                    // Bad lead byte: report it and skip it.
                    res.emit         = 1'b1;
                    res.bad_sequence = 1'b1;
                    res.code_point   = {{(CpW-ByteW){1'b0}}, b};
                end
                // A sequence opened on the final byte is truncated at once.
                if (!res.emit && eos) begin
                    res.emit         = 1'b1;
                    res.bad_sequence = 1'b1;
                    res.last_result  = 1'b1;
                    n_partial        = '0;
                    n_pending        = PendNone;
                end
            end
        end
    end

    // Sequence state advances only when the held byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= PendNone;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

    assign o_result = res;

endmodule

FILE: rtl/u8d_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8d_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  u8d_pkg::t_result i_result,
    output logic             o_free,
    u8d_cp_if.source         o_cp
);
    import u8d_pkg::*;

    logic           r_valid;
    logic [CpW-1:0] r_code_point;
    logic           r_bad;
    logic           r_last;

    // Free when empty or when the held item leaves at this edge.
    assign o_free = !r_valid || o_cp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire && i_result.emit) begin
            r_valid <= 1'b1;
        end else if (o_cp.ready) begin
            r_valid <= 1'b0;
        end
        if (i_fire && i_result.emit) begin
            r_code_point <= i_result.code_point;
            r_bad        <= i_result.bad_sequence;
            r_last       <= i_result.last_result;
        end
    end

    assign o_cp.valid        = r_valid;
    assign o_cp.code_point   = r_code_point;
    assign o_cp.bad_sequence = r_bad;
    assign o_cp.last_result  = r_last;

endmodule

FILE: rtl/utf8_to_code_point_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// Decodes a UTF-8 byte stream, one byte per item, into code points of up to
// 31 bits, with error items for bad lead bytes and truncated sequences.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  i_byte   | in        | in_byte[7:0], end_of_string
//  o_cp     | out       | code_point[30:0], bad_sequence, last_result
//  i_cfg    | in        | wide_mode (always ready)
//
//  One byte per cycle sustained while the result side takes every result.
//  A byte goes from the input register through the decode logic to the
//  result register. Reset clears the open sequence and sets wide_mode. When
//  a result waits unread, one more byte is held in the input register and
//  further input stalls until the result is taken.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8d_byte_if.sink   i_byte,
    u8d_cfg_if.sink    i_cfg,
    u8d_cp_if.source   o_cp
);
    import u8d_pkg::*;

    logic    r_wide_mode;
    logic    held_valid;
    t_item   in_item;
    t_item   held_item;
    logic    out_free;
    logic    fire;
    t_result result;

    // Mode register; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= WideModeReset;
        end else if (i_cfg.valid) begin
            r_wide_mode <= i_cfg.wide_mode;
        end
    end

    assign in_item.in_byte       = i_byte.in_byte;
    assign in_item.end_of_string = i_byte.end_of_string;

    // The held byte is decoded once the result register can take a result.
    assign fire = held_valid && out_free;

    u8d_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_byte.valid),
        .o_ready  (i_byte.ready),
        .i_item   (in_item),
        .i_consume(fire),
        .o_valid  (held_valid),
        .o_item   (held_item)
    );

    u8d_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_wide_mode(r_wide_mode),
        .i_item     (held_item),
        .o_result   (result)
    );

    u8d_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_result(result),
        .o_free  (out_free),
        .o_cp    (o_cp)
    );

endmodule

FILE: rtl/u8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the top level's ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [30:0] i_code_point,
    input logic        i_bad_sequence
);

    // A result that is not taken stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // An error result carries either zero or the offending lead byte.
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_sequence |->
            (i_code_point[30:8] == 23'd0) &&
            ((i_code_point[7:0] == 8'd0) || (i_code_point[7:6] == 2'b10) ||
             (i_code_point[7:4] == 4'hf)))
        else $error("error result holds an impossible value");

    // Reset leaves no result on offer.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // Reset empties the input register, so input is open again.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready straight after reset");

endmodule

bind utf8_to_code_point_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_byte.ready),
    .i_out_valid   (o_cp.valid),
    .i_out_ready   (o_cp.ready),
    .i_code_point  (o_cp.code_point),
    .i_bad_sequence(o_cp.bad_sequence)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Drives byte items into the decoder and checks every code point item that it
// returns against a scoreboard that tracks the open sequence and the width
// mode. A short directed set covers the byte classes and the error cases.
// Random strings of well-formed characters, noise and cut-short sequences
// follow, with random gaps on both sides, stretches with no gaps, a long
// back-pressure period on the result side and changes of width mode.
// ----------------------------------------------------------------------------
module testbench;
    import u8d_pkg::*;

    // One expected decoded item.
    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           bad_sequence;
        logic           last_result;
    } t_cp_item;

    // Tracks the decoder state and holds the code points still to come.
    class code_point_scoreboard;
        t_cp_item         expected_cps[$];
        logic [CpW-1:0]   partial_value;
        logic [PendW-1:0] bytes_pending;
        logic             wide_mode;
        int               mismatches;
        int               checked;
        int               error_items;

        function new();
            partial_value = '0;
            bytes_pending = PendNone;
            wide_mode     = WideModeReset;
            mismatches    = 0;
            checked       = 0;
            error_items   = 0;
        endfunction

        function void push_cp(logic [CpW-1:0] cp, logic bad, logic last);
            t_cp_item item;
            item.code_point   = cp;
            item.bad_sequence = bad;
            item.last_result  = last;
            expected_cps = {expected_cps, item};
        endfunction

        // Works out what one accepted byte item leads to.
        function void take_byte(logic [ByteW-1:0] b, logic eos);
            if (bytes_pending != PendNone) begin
                // Continuation byte: only the low six bits count.
                partial_value = {partial_value[CpW-ContBits-1:0], b[ContBits-1:0]};
                bytes_pending = bytes_pending - 1'b1;
                if (bytes_pending == PendNone) begin
                    push_cp(partial_value, 1'b0, eos);
                    partial_value = '0;
                end else if (eos) begin
                    partial_value = '0;
                    bytes_pending = PendNone;
                    push_cp('0, 1'b1, 1'b1);
                end
                return;
            end

            // Lead byte.
            if ((b & MaskTop1) == '0) begin
                push_cp(CpW'(b), 1'b0, eos);
                return;
            end else if ((b & MaskTop3) == Lead2) begin
                partial_value = CpW'(b & MaskData2);
                bytes_pending = Pend2;
            end else if ((b & MaskTop4) == Lead3) begin
                partial_value = CpW'(b & MaskData3);
                bytes_pending = Pend3;
            end else if (wide_mode && (b & MaskTop5) == Lead4) begin
                partial_value = CpW'(b & MaskData4);
                bytes_pending = Pend4;
            end else if (wide_mode && (b & MaskTop6) == Lead5) begin
                partial_value = CpW'(b & MaskData5);
                bytes_pending = Pend5;
            end else if (wide_mode && (b & MaskTop7) == Lead6) begin
                partial_value = CpW'(b & MaskData6);
                bytes_pending = Pend6;
            end else begin
                push_cp(CpW'(b), 1'b1, eos);
                return;
            end

            // A lead byte that ends the string leaves its sequence cut short.
            if (eos) begin
                partial_value = '0;
                bytes_pending = PendNone;
                push_cp('0, 1'b1, 1'b1);
            end
        endfunction

        task report(input string what);
            mismatches++;
            $display("ERROR at %0t ns: %s", $time, what);
        endtask

        // Compares one returned item with the oldest expectation.
        task check_code_point(input logic [CpW-1:0] cp, input logic bad,
                              input logic last);
            t_cp_item want;
            checked++;
            if (bad)
                error_items++;
            if (expected_cps.size() == 0) begin
                report($sformatf("unexpected item cp=%h bad=%b last=%b", cp, bad, last));
                return;
            end
            want = expected_cps.pop_front();
            if (cp !== want.code_point)
                report($sformatf("code_point %h, expected %h", cp, want.code_point));
            if (bad !== want.bad_sequence)
                report($sformatf("bad_sequence %b, expected %b", bad, want.bad_sequence));
            if (last !== want.last_result)
                report($sformatf("last_result %b, expected %b", last, want.last_result));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    u8d_byte_if byte_ch ();
    u8d_cfg_if  cfg_ch ();
    u8d_cp_if   cp_ch ();

    utf8_to_code_point_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_cp    (cp_ch)
    );

    code_point_scoreboard sb = new();

    int   tx_gap_max     = 2;
    int   rx_stall_max   = 3;
    int   rx_hold_cycles = 0;
    int   bytes_sent     = 0;
    logic wide_now       = WideModeReset;

    // Offers one byte item after a random gap and waits for it to be taken.
    task automatic send_byte(input logic [ByteW-1:0] b, input logic eos);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.in_byte       <= b;
        byte_ch.end_of_string <= eos;
        do @(posedge clk); while (!byte_ch.ready);
        sb.take_byte(b, eos);
        bytes_sent++;
    endtask

    // Stops offering and waits until every expected item has come back.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (sb.expected_cps.size() != 0)
            @(posedge clk);
        // Bytes inside an open sequence return nothing, so allow the pipeline
        // to empty as well.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_wide_mode(input logic mode);
        wait_drained();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.wide_mode <= mode;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.wide_mode = mode;
        wide_now     = mode;
    endtask

    function automatic logic [ByteW-1:0] lead_byte(input int len);
        logic [ByteW-1:0] r;
        r = ByteW'($urandom);
        case (len)
            1:       return r & ~MaskTop1;
            2:       return Lead2 | (r & MaskData2);
            3:       return Lead3 | (r & MaskData3);
            4:       return Lead4 | (r & MaskData4);
            5:       return Lead5 | (r & MaskData5);
            default: return Lead6 | (r & MaskData6);
        endcase
    endfunction

    // The decoder does not check the top bits, so now and then send any byte.
    function automatic logic [ByteW-1:0] cont_byte();
        if ($urandom_range(0, 7) == 0)
            return ByteW'($urandom);
        return MaskTop1 | (ByteW'($urandom) & MaskCont);
    endfunction

    // One string: mostly well-formed characters, some noise, and at times a
    // sequence that the end of the string cuts short.
    task automatic send_random_string();
        logic [ByteW-1:0] str_q[$];
        int nchars;
        int len;
        nchars = $urandom_range(1, 6);
        for (int c = 0; c < nchars; c++) begin
            if ($urandom_range(0, 9) == 0) begin
                str_q = {str_q, ByteW'($urandom)};
            end else begin
                len = wide_now ? $urandom_range(1, 6) : $urandom_range(1, 3);
                str_q = {str_q, lead_byte(len)};
                repeat (len - 1) str_q = {str_q, cont_byte()};
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(2, 6);
            str_q = {str_q, lead_byte(len)};
            repeat ($urandom_range(0, len - 2)) str_q = {str_q, cont_byte()};
        end
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_string();
    endtask

    // Result side: random stalls, or one long hold when asked for.
    initial begin : result_sink
        int stall;
        cp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                cp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cp_ch.ready <= 1'b1;
            do @(posedge clk); while (!cp_ch.valid);
            sb.check_code_point(cp_ch.code_point, cp_ch.bad_sequence, cp_ch.last_result);
        end
    end

    // Stimulus.
    initial begin
        byte_ch.valid         <= 1'b0;
        byte_ch.in_byte       <= '0;
        byte_ch.end_of_string <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.wide_mode      <= WideModeReset;
        rst_n                 <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single bytes at both ends of the ASCII range.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        // Two and three byte characters.
        send_byte(8'hc2, 1'b0);
        send_byte(8'ha9, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hac, 1'b0);
        // The largest six byte value, ending the string.
        send_byte(8'hfd, 1'b0);
        repeat (4) send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b1);
        // Bad lead bytes, one of them ending a string.
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b1);
        // Sequences cut short, one by its own lead byte.
        send_byte(8'hf0, 1'b0);
        send_byte(8'h90, 1'b1);
        send_byte(8'hc3, 1'b1);
        // A five byte sequence left open across a change to narrow mode.
        send_byte(8'hf8, 1'b0);
        write_wide_mode(1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b1);
        // Wide lead bytes are bad in narrow mode.
        send_byte(8'hf0, 1'b0);
        send_byte(8'hfd, 1'b1);

        // Narrow mode with gaps on both sides.
        tx_gap_max   = 5;
        rx_stall_max = 5;
        run_random(200);

        // Wide mode at full rate.
        write_wide_mode(1'b1);
        tx_gap_max   = 0;
        rx_stall_max = 0;
        run_random(200);

        // Hold the result side long enough that the input stalls.
        rx_hold_cycles = 300;
        run_random(80);
        wait_drained();

        tx_gap_max   = 5;
        rx_stall_max = 5;
        run_random(250);

        write_wide_mode(1'b0);
        tx_gap_max   = 3;
        rx_stall_max = 5;
        run_random(120);

        write_wide_mode(1'b1);
        tx_gap_max   = 5;
        rx_stall_max = 2;
        run_random(100);

        wait_drained();
        $display("Summary: %0d bytes sent, %0d items checked (%0d error items),",
                 bytes_sent, sb.checked, sb.error_items);
        $display("         in narrow and wide mode, with gaps, full rate and a long hold.");
        if (sb.mismatches == 0 && sb.expected_cps.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
